// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the sliding window extreme RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cond |-> prop
`define SWE_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication: cond |=> prop
`define SWE_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/swe_pkg.sv =====
// Package for the sliding window extreme block: field widths, register
// indexes, the deque entry type and the command struct sent to every cell.
package swe_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int AGE_W      = 7;
  localparam int WIN_W      = 7;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  typedef logic [WIN_W-1:0] win_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam age_t AGE_MAX = 7'd127;
  localparam cnt_t CNT_MAX = 7'd127;

  // Register indexes
  localparam cfg_idx_t CFG_WINDOW_SIZE = 1'b0;
  localparam cfg_idx_t CFG_FIND_MIN    = 1'b1;

  typedef struct packed {
    logic                       valid;
    age_t                       age;
    logic signed [SAMPLE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                       age_step;  // age every entry, drop expired ones
    logic                       shift;     // move every entry one cell to the front
    logic                       pop_check; // back entry leaves if dominated
    logic                       push;      // write the sample behind the back
    logic                       clear;     // end of sequence: empty the deque
    logic                       find_min;
    win_t                       eff;
    logic signed [SAMPLE_W-1:0] x;
  } cell_cmd_t;

endpackage

// ===== rtl/core/swe_in_if.sv =====
// Input channel of the sliding window extreme block: one sample per beat.
// Uses swe_pkg for the field width.
interface swe_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [swe_pkg::SAMPLE_W-1:0] sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

// ===== rtl/core/swe_out_if.sv =====
// Result channel of the sliding window extreme block: one result per beat.
// Uses swe_pkg for the field width.
interface swe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [swe_pkg::SAMPLE_W-1:0] extreme;
  logic                                window_filled;
  logic                                seq_end;

  modport source (output valid, output extreme, output window_filled, output seq_end,
                  input ready);
  modport sink (input valid, input extreme, input window_filled, input seq_end,
                output ready);
endinterface

// ===== rtl/core/swe_cell.sv =====
// One deque cell: holds a value, its age and a valid bit.
// Takes its neighbor's entry on a shift; commands come from swe_ctrl via swe_pkg.
module swe_cell (
  input  logic               clk,
  input  logic               rst,
  input  swe_pkg::cell_cmd_t cmd,
  input  swe_pkg::entry_t    right,
  input  logic               left_valid,
  input  logic               at_tail,
  output swe_pkg::entry_t    ent,
  output logic               pop
);

  logic                                valid;
  swe_pkg::age_t                       age;
  logic signed [swe_pkg::SAMPLE_W-1:0] value;
  swe_pkg::age_t                       age_inc;
  logic                                expire;
  logic                                back;
  logic                                dom;
  logic                                target;

  assign ent = '{valid: valid, age: age, value: value};

  assign age_inc = (age == swe_pkg::AGE_MAX) ? age : age + 1'b1;
  assign expire  = (cmd.eff != '0) && (age_inc >= cmd.eff);
  assign back    = valid && !right.valid;
  assign dom     = cmd.find_min ? (cmd.x < value) : (cmd.x > value);
  assign pop     = cmd.pop_check && back && dom;
  // write behind the back, or overwrite the back when the row is full
  assign target  = cmd.push && ((!valid && left_valid) || (valid && at_tail));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.shift) begin
      valid <= right.valid;
    end else if (cmd.age_step && valid && expire) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b0;
    end else if (target) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      age   <= right.age;
      value <= right.value;
    end else if (cmd.age_step) begin
      age <= age_inc;
    end else if (target) begin
      age   <= '0;
      value <= cmd.x;
    end
  end

endmodule

// ===== rtl/core/swe_ctrl.sv =====
// Sequencer of the sliding window extreme block: configuration registers,
// deque length, sample count and the result register. Uses swe_pkg and both
// channel interfaces.
`include "assert_macros.svh"

module swe_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  swe_pkg::cfg_idx_t              cfg_index,
  input  logic [swe_pkg::CFG_DATA_W-1:0] cfg_data,
  swe_in_if.sink                         samples,
  swe_out_if.source                      results,
  input  swe_pkg::entry_t                front,
  input  logic                           pop_any,
  output swe_pkg::cell_cmd_t             cmd
);

  localparam int LenW   = $clog2(DEPTH + 1);
  localparam int EffCap = (DEPTH < 127) ? DEPTH : 127;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_POP   = 4'b0100,
    ST_PUSH  = 4'b1000
  } state_t;

  state_t                              state;
  logic [LenW-1:0]                     len;
  swe_pkg::cnt_t                       seen_count;
  swe_pkg::win_t                       window_size;
  logic                                find_min;
  logic signed [swe_pkg::SAMPLE_W-1:0] x;
  logic                                lat_last;
  logic                                out_valid;
  logic signed [swe_pkg::SAMPLE_W-1:0] out_extreme;
  logic                                out_filled;
  logic                                out_seq_end;

  swe_pkg::win_t eff;
  swe_pkg::cnt_t seen_next;
  logic          filled;
  logic          accept;
  logic          out_load;
  logic          shift_go;

  assign eff = (window_size > swe_pkg::win_t'(EffCap)) ? swe_pkg::win_t'(EffCap)
                                                        : window_size;
  assign seen_next = (seen_count == swe_pkg::CNT_MAX) ? seen_count : seen_count + 1'b1;
  assign filled    = (eff == '0) || (seen_next >= eff);

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign out_load      = (state == ST_PUSH) && (!out_valid || results.ready);
  assign shift_go      = (state == ST_SHIFT) && !front.valid && (len != '0);

  assign cmd = '{age_step:  accept,
                 shift:     shift_go,
                 pop_check: (state == ST_POP),
                 push:      out_load,
                 clear:     out_load && lat_last,
                 find_min:  find_min,
                 eff:       eff,
                 x:         x};

  assign results.valid         = out_valid;
  assign results.extreme       = out_extreme;
  assign results.window_filled = out_filled;
  assign results.seq_end       = out_seq_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      len         <= '0;
      seen_count  <= '0;
      window_size <= '0;
      find_min    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swe_pkg::CFG_WINDOW_SIZE: window_size <= cfg_data;
          swe_pkg::CFG_FIND_MIN:    find_min    <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (shift_go) begin
            len <= len - 1'b1;
          end else begin
            state <= ST_POP;
          end
        end
        ST_POP: begin
          if (pop_any) begin
            len <= len - 1'b1;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_load) begin
            state <= ST_IDLE;
            if (lat_last) begin
              len        <= '0;
              seen_count <= '0;
            end else begin
              seen_count <= seen_next;
              if (len != LenW'(DEPTH)) begin
                len <= len + 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x        <= samples.sample;
      lat_last <= samples.last;
    end
    if (out_load) begin
      out_extreme <= front.valid ? front.value : x;
      out_filled  <= filled;
      out_seq_end <= lat_last;
    end
  end

  `SWE_ASSERT_IMPL(a_len_bound, 1'b1, len <= LenW'(DEPTH), "deque length above depth")
  `SWE_ASSERT_IMPL(a_front_len, (state == ST_POP) || (state == ST_PUSH),
                   front.valid == (len != '0), "front valid disagrees with deque length")
  `SWE_ASSERT_IMPL(a_pop_phase, state != ST_POP, !pop_any, "cell popped outside pop phase")
  `SWE_ASSERT_NEXT(a_last_clear, out_load && lat_last, (len == '0) && (seen_count == '0),
                   "sequence end did not clear state")

endmodule

// ===== rtl/core/sliding_window_extreme.sv =====
// Top level of the sliding window extreme block: a row of deque cells and
// the sequencer. Uses swe_pkg, swe_in_if, swe_out_if, swe_cell and swe_ctrl.
//
//   channel   dir  beat payload                          handshake
//   samples   in   sample[31:0] signed, last             valid/ready
//   results   out  extreme[31:0] signed, window_filled,  valid/ready
//                  seq_end
//   cfg       in   cfg_index, cfg_data[6:0]              cfg_we, no stall
//
// Order: accept the sample, shift out the D entries expiring at the front,
// pop the P dominated entries from the back, push the sample. Shifts and pops
// run one per cycle through the cell row. A fixed window gives D at most one.
// Reset: rst is synchronous; it empties the deque and clears the count and
// the registers. No clearing pass is needed.
// Stalls: a held result is kept in the output register while the next sample
// is taken and processed; only the final write waits on results.ready.
module sliding_window_extreme #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  swe_pkg::cfg_idx_t              cfg_index,
  input  logic [swe_pkg::CFG_DATA_W-1:0] cfg_data,
  swe_in_if.sink                         samples,
  swe_out_if.source                      results
);

  swe_pkg::cell_cmd_t cmd;
  swe_pkg::entry_t    ent [DEPTH];
  swe_pkg::entry_t    tail_pad;
  logic [DEPTH-1:0]   pop_vec;
  logic               pop_any;

  // Past the last cell there is never an entry.
  assign tail_pad = '0;
  // At most one cell is the back, so at most one bit is set.
  assign pop_any  = |pop_vec;

  swe_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .results   (results),
    .front     (ent[0]),
    .pop_any   (pop_any),
    .cmd       (cmd)
  );

  // Cell 0 holds the front (oldest, the current extreme); entries advance
  // toward cell 0 when an expired front entry leaves.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    swe_pkg::entry_t right;
    logic            left_valid;

    if (i == DEPTH - 1) begin : g_tail
      assign right = tail_pad;
    end else begin : g_mid
      assign right = ent[i+1];
    end

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_valid = ent[i-1].valid;
    end

    swe_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .right      (right),
      .left_valid (left_valid),
      .at_tail    ((i == DEPTH - 1) ? 1'b1 : 1'b0),
      .ent        (ent[i]),
      .pop        (pop_vec[i])
    );
  end

endmodule
